[design/aeps_pkg.sv]
// Shared types, constants and helper functions of the active/expired priority scheduler.
package aeps_pkg;

  localparam int NumPrio  = 32;
  localparam int MaxTasks = 16;
  localparam int NumSets  = 2;
  localparam int TaskW    = 4;
  localparam int PrioW    = $clog2(NumPrio);

  typedef logic [TaskW-1:0]   task_t;
  typedef logic [PrioW-1:0]   prio_t;
  typedef logic [NumPrio-1:0] pmap_t;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_ELECT = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    task_t      task_id;
    logic [4:0] priority_req;
    task_t      current_id;
    logic       current_is_idle;
    logic       current_terminated;
    logic       current_slice_expired;
    logic [4:0] current_priority;
  } req_t;

  typedef struct packed {
    task_t next_id;
    logic  is_idle;
    logic  error;
    logic  reload_slice;
  } rsp_t;

  // Write and read-address controls for one set of run queues.
  typedef struct packed {
    prio_t hd_raddr;
    prio_t tl_raddr;
    logic  hda_we;
    prio_t hda_addr;
    task_t hda_data;
    logic  hdb_we;
    prio_t hdb_addr;
    task_t hdb_data;
    logic  tl_we;
    prio_t tl_waddr;
    task_t tl_wdata;
    logic  set_we;
    prio_t set_addr;
    logic  clr_we;
    prio_t clr_addr;
  } qset_wr_t;

  typedef struct packed {
    pmap_t map;
    task_t hd;
    task_t tl;
    logic  eq;
  } qset_rd_t;

  function automatic prio_t clamp_prio(logic [4:0] p);
    return (32'(p) >= NumPrio) ? prio_t'(NumPrio - 1) : prio_t'(p);
  endfunction

  // Index of the lowest set bit; zero for an empty map.
  function automatic prio_t lowest_prio(pmap_t m);
    pmap_t oh;
    prio_t idx;
    oh  = m & (~m + pmap_t'(1));
    idx = '0;
    for (int i = 0; i < NumPrio; i++) begin
      if (oh[i]) idx = idx | prio_t'(i);
    end
    return idx;
  endfunction

endpackage

[design/aeps_stream_if.sv]
// Valid/ready stream interface carrying one payload struct.
interface aeps_stream_if #(parameter type payload_t = aeps_pkg::req_t);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/aeps_qset.sv]
// One set of per-priority run queues: head and tail files, head-equals-tail flags, bitmap.
module aeps_qset (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aeps_pkg::qset_wr_t wr_i,
  output aeps_pkg::qset_rd_t rd_o
);
  import aeps_pkg::*;

  task_t head_q [NumPrio];
  task_t tail_q [NumPrio];
  logic  eq_q   [NumPrio];
  task_t head_d [NumPrio];
  task_t tail_d [NumPrio];
  logic  eq_d   [NumPrio];
  pmap_t map_q, map_d;

  always_comb begin
    for (int i = 0; i < NumPrio; i++) begin
      head_d[i] = head_q[i];
      tail_d[i] = tail_q[i];
      if (wr_i.hda_we && wr_i.hda_addr == prio_t'(i)) head_d[i] = wr_i.hda_data;
      // append after unlink: the second head port wins
      if (wr_i.hdb_we && wr_i.hdb_addr == prio_t'(i)) head_d[i] = wr_i.hdb_data;
      if (wr_i.tl_we && wr_i.tl_waddr == prio_t'(i)) tail_d[i] = wr_i.tl_wdata;
      eq_d[i] = (head_d[i] == tail_d[i]);
    end
  end

  always_comb begin
    map_d = map_q;
    if (wr_i.clr_we) map_d[wr_i.clr_addr] = 1'b0;
    if (wr_i.set_we) map_d[wr_i.set_addr] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumPrio; i++) begin
      head_q[i] <= head_d[i];
      tail_q[i] <= tail_d[i];
      eq_q[i]   <= eq_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
    end else begin
      map_q <= map_d;
    end
  end

  assign rd_o.map = map_q;
  assign rd_o.hd  = head_q[wr_i.hd_raddr];
  assign rd_o.eq  = eq_q[wr_i.hd_raddr];
  assign rd_o.tl  = tail_q[wr_i.tl_raddr];

endmodule

[design/active_expired_priority_scheduler.sv]
// Top level of the active/expired priority scheduler.
// Requests (enqueue, dequeue, elect) are taken one per cycle while the response
// side is not stalled, and each gives exactly one response, in order: the request
// lands in an input register, and then a single pass of logic (bitmap select and
// swap, lowest-bit priority encode, head/tail and link register-file access,
// unlink and append) updates the queues and loads the response register. A
// stalled response holds the next request in the input register, so at most two
// requests are in flight. Queues are FIFO per priority, priority 0 highest; the
// bitmaps are cleared at reset and no clearing pass is needed before use.
module active_expired_priority_scheduler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  aeps_stream_if.sink          req_i,
  aeps_stream_if.source        rsp_o
);
  import aeps_pkg::*;

  req_t     req_q;
  logic     req_v_q;
  rsp_t     rsp_q, rsp_d;
  logic     rsp_v_q;
  logic     sel_q;
  task_t    next_link_q [MaxTasks];
  task_t    prev_link_q [MaxTasks];
  qset_wr_t wr [NumSets];
  qset_rd_t rd [NumSets];

  logic  advance, fire;
  logic  is_enq, is_deq, is_el, deq_err, el_pop, el_idle, requeue, swap;
  logic  act_e, aset;
  prio_t preq, cprio, p_sel, rprio, aprio, tl_raddr;
  task_t rtask, atask, hd, tl, nl_rd, pl_rd;
  logic  eq, task_ok, cur_ok;
  logic  do_remove, rm, hit_h, hit_t, r_clear, r_newhead, r_newtail, r_splice;
  logic  do_append, a_empty;
  logic  nl_we, pl_we;
  task_t nl_waddr, nl_wdata, pl_waddr, pl_wdata;

  for (genvar s = 0; s < NumSets; s++) begin : g_set
    aeps_qset u_qset (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .wr_i  (wr[s]),
      .rd_o  (rd[s])
    );
  end

  // handshake: the input register drains whenever the response register can load
  assign advance     = !rsp_v_q || rsp_o.ready;
  assign fire        = req_v_q && advance;
  assign req_i.ready = !req_v_q || advance;
  assign rsp_o.valid = rsp_v_q;
  assign rsp_o.payload = rsp_q;

  // decode
  always_comb begin
    preq    = clamp_prio(req_q.priority_req);
    cprio   = clamp_prio(req_q.current_priority);
    task_ok = ({1'b0, req_q.task_id} < (TaskW + 1)'(MaxTasks));
    cur_ok  = ({1'b0, req_q.current_id} < (TaskW + 1)'(MaxTasks));
    is_enq  = (req_q.cmd == CMD_ENQ) && task_ok;
    is_deq  = (req_q.cmd == CMD_DEQ) && task_ok;
    is_el   = (req_q.cmd == CMD_ELECT);
    deq_err = is_deq && !req_q.current_is_idle && (req_q.task_id == req_q.current_id);

    swap    = is_el && (rd[sel_q].map == '0) && (rd[!sel_q].map != '0);
    act_e   = sel_q ^ swap;
    p_sel   = lowest_prio(rd[act_e].map);
    el_pop  = is_el && (rd[act_e].map != '0);
    el_idle = is_el && (rd[act_e].map == '0);
    requeue = el_pop && !req_q.current_is_idle && !req_q.current_terminated && cur_ok;

    rprio   = is_el ? p_sel : preq;
    hd      = rd[act_e].hd;
    eq      = rd[act_e].eq;
    rtask   = is_el ? hd : req_q.task_id;

    aset     = is_el ? (req_q.current_slice_expired ? !act_e : act_e) : sel_q;
    aprio    = is_enq ? preq : cprio;
    atask    = is_enq ? req_q.task_id : req_q.current_id;
    tl_raddr = is_el ? cprio : preq;
    tl       = rd[aset].tl;
  end

  assign nl_rd = next_link_q[rtask];
  assign pl_rd = prev_link_q[rtask];

  // unlink, then append
  always_comb begin
    do_remove = (is_deq && !deq_err) || el_pop;
    rm        = do_remove && rd[act_e].map[rprio];
    hit_h     = (hd == rtask);
    hit_t     = (tl == rtask);
    r_clear   = rm && hit_h && eq;
    r_newhead = rm && hit_h && !eq;
    r_newtail = rm && !hit_h && hit_t;
    r_splice  = rm && !hit_h && !hit_t;

    do_append = is_enq || requeue;
    a_empty   = !rd[aset].map[aprio] || (r_clear && (aset == act_e) && (aprio == rprio));

    nl_we    = (do_append && !a_empty) || r_splice;
    nl_waddr = r_splice ? pl_rd : tl;
    nl_wdata = r_splice ? nl_rd : atask;
    pl_we    = nl_we;
    pl_waddr = r_splice ? nl_rd : atask;
    pl_wdata = r_splice ? pl_rd : tl;
  end

  always_comb begin
    for (int s = 0; s < NumSets; s++) begin
      wr[s].hd_raddr = rprio;
      wr[s].tl_raddr = tl_raddr;
      wr[s].hda_we   = fire && r_newhead && (act_e == 1'(s));
      wr[s].hda_addr = rprio;
      wr[s].hda_data = nl_rd;
      wr[s].hdb_we   = fire && do_append && a_empty && (aset == 1'(s));
      wr[s].hdb_addr = aprio;
      wr[s].hdb_data = atask;
      wr[s].tl_we    = fire && ((do_append && (aset == 1'(s))) ||
                                (r_newtail && (act_e == 1'(s))));
      wr[s].tl_waddr = do_append ? aprio : rprio;
      wr[s].tl_wdata = do_append ? atask : pl_rd;
      wr[s].set_we   = fire && do_append && (aset == 1'(s));
      wr[s].set_addr = aprio;
      wr[s].clr_we   = fire && r_clear && (act_e == 1'(s));
      wr[s].clr_addr = rprio;
    end
  end

  always_comb begin
    rsp_d.next_id      = el_pop ? hd : '0;
    rsp_d.is_idle      = el_idle;
    rsp_d.error        = deq_err;
    rsp_d.reload_slice = requeue && req_q.current_slice_expired;
  end

  always_ff @(posedge clk_i) begin
    if (fire && nl_we) next_link_q[nl_waddr] <= nl_wdata;
    if (fire && pl_we) prev_link_q[pl_waddr] <= pl_wdata;
    if (req_i.valid && req_i.ready) req_q <= req_i.payload;
    if (fire) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_v_q <= 1'b0;
      rsp_v_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        req_v_q <= 1'b1;
      end else if (fire) begin
        req_v_q <= 1'b0;
      end
      if (fire) begin
        rsp_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_v_q <= 1'b0;
      end
      if (fire) sel_q <= sel_q ^ swap;
    end
  end

endmodule

[design/aeps_checker.sv]
// Port-level checks of the scheduler, attached to the top level by bind.
module aeps_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input aeps_pkg::rsp_t rsp_payload_i
);
  import aeps_pkg::*;

  logic [1:0] pend_q;
  logic       req_fire, rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // count requests accepted whose response is not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_ready_i |-> req_ready_i)
    else $error("request side stalled while the response side is ready");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 2'd3) && (!rsp_valid_i || pend_q != 2'd0))
    else $error("response count out of step with requests");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && pend_q == 2'd0) |=> ##1 rsp_valid_i)
    else $error("response missing two cycles after request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_payload_i)))
    else $error("stalled response changed");

endmodule

bind active_expired_priority_scheduler aeps_checker u_aeps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_payload_i(rsp_o.payload)
);

[dv/tb.sv]
// Self-checking testbench for the active/expired priority scheduler.
`timescale 1ns / 100ps

module tb;
  import aeps_pkg::*;

  // Mirror of both run-queue sets; predicts one response per accepted request.
  class runqueue_mirror;
    bit               act_sel;
    bit [NumPrio-1:0] run_map [NumSets];
    bit [TaskW-1:0]   q_first [NumSets*NumPrio];
    bit [TaskW-1:0]   q_last  [NumSets*NumPrio];
    bit [TaskW-1:0]   link_fwd  [MaxTasks];
    bit [TaskW-1:0]   link_back [MaxTasks];
    rsp_t             sched_rsp_q [$];
    int               n_fail;
    int               n_checked;
    int               n_cmd [4];
    int               n_idle;
    int               n_reload;
    int               n_error;

    function automatic int clamp(logic [4:0] p);
      return (int'(p) >= NumPrio) ? NumPrio - 1 : int'(p);
    endfunction

    function automatic void append(bit s, int p, bit [TaskW-1:0] t);
      int q;
      q = int'(s) * NumPrio + p;
      if (!run_map[s][p]) begin
        q_first[q] = t;
      end else begin
        link_fwd[q_last[q]] = t;
        link_back[t] = q_last[q];
      end
      q_last[q] = t;
      run_map[s][p] = 1'b1;
    endfunction

    function automatic void unlink(bit s, int p, bit [TaskW-1:0] t);
      int q;
      q = int'(s) * NumPrio + p;
      if (!run_map[s][p]) return;
      if (q_first[q] == t && q_last[q] == t) begin
        run_map[s][p] = 1'b0;
      end else if (q_first[q] == t) begin
        q_first[q] = link_fwd[t];
      end else if (q_last[q] == t) begin
        q_last[q] = link_back[t];
      end else begin
        link_fwd[link_back[t]] = link_fwd[t];
        link_back[link_fwd[t]] = link_back[t];
      end
    endfunction

    function automatic rsp_t note_request(req_t r);
      rsp_t           o;
      bit             a;
      int             p;
      bit [TaskW-1:0] nx;
      o = '0;
      a = act_sel;
      n_cmd[r.cmd]++;
      case (r.cmd)
        CMD_ENQ: begin
          if (int'(r.task_id) < MaxTasks) append(a, clamp(r.priority_req), r.task_id);
        end
        CMD_DEQ: begin
          if (int'(r.task_id) < MaxTasks) begin
            if (!r.current_is_idle && r.task_id == r.current_id) o.error = 1'b1;
            else unlink(a, clamp(r.priority_req), r.task_id);
          end
        end
        CMD_ELECT: begin
          // swap sets when only the expired one holds tasks
          if (run_map[a] == '0 && run_map[!a] != '0) begin
            act_sel = !act_sel;
            a = act_sel;
          end
          if (run_map[a] == '0) begin
            o.is_idle = 1'b1;
          end else begin
            p = NumPrio;
            for (int i = NumPrio - 1; i >= 0; i--) begin
              if (run_map[a][i]) p = i;
            end
            nx = q_first[int'(a) * NumPrio + p];
            unlink(a, p, nx);
            o.next_id = nx;
            if (!r.current_is_idle && !r.current_terminated &&
                int'(r.current_id) < MaxTasks) begin
              if (r.current_slice_expired) begin
                append(!a, clamp(r.current_priority), r.current_id);
                o.reload_slice = 1'b1;
              end else begin
                append(a, clamp(r.current_priority), r.current_id);
              end
            end
          end
        end
        default: ;
      endcase
      n_idle   += o.is_idle;
      n_reload += o.reload_slice;
      n_error  += o.error;
      sched_rsp_q.push_back(o);
      return o;
    endfunction

    function automatic void check_response(rsp_t got);
      rsp_t exp_rsp;
      if (sched_rsp_q.size() == 0) begin
        $display("%0t: response with nothing pending, got %p", $time, got);
        n_fail++;
        return;
      end
      exp_rsp = sched_rsp_q.pop_front();
      n_checked++;
      if (got !== exp_rsp) n_fail++;
      if (got.next_id !== exp_rsp.next_id)
        $display("%0t: next_id expected %0d got %0d", $time, exp_rsp.next_id, got.next_id);
      if (got.is_idle !== exp_rsp.is_idle)
        $display("%0t: is_idle expected %0b got %0b", $time, exp_rsp.is_idle, got.is_idle);
      if (got.error !== exp_rsp.error)
        $display("%0t: error expected %0b got %0b", $time, exp_rsp.error, got.error);
      if (got.reload_slice !== exp_rsp.reload_slice)
        $display("%0t: reload_slice expected %0b got %0b", $time, exp_rsp.reload_slice,
                 got.reload_slice);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  aeps_stream_if #(.payload_t(req_t)) req_if ();
  aeps_stream_if #(.payload_t(rsp_t)) rsp_if ();

  active_expired_priority_scheduler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  runqueue_mirror sb;
  int             idle_mode;  // 0 none, 1 sender, 2 receiver, 3 both

  // Rough view of where each task sits, used only to steer stimulus.
  bit             task_queued [MaxTasks];
  bit [4:0]       task_prio   [MaxTasks];
  bit             task_set    [MaxTasks];
  bit [TaskW-1:0] running_id;
  bit             running_idle;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    int stall_pct;
    stall_pct = (idle_mode == 2) ? 66 : (idle_mode == 3) ? 31 : 0;
    if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic req_t mk(cmd_e c, bit [3:0] tid, bit [4:0] pr, bit [3:0] cur,
                              bit idl, bit trm, bit xp, bit [4:0] cpr);
    req_t r;
    r.cmd                   = c;
    r.task_id               = tid;
    r.priority_req          = pr;
    r.current_id            = cur;
    r.current_is_idle       = idl;
    r.current_terminated    = trm;
    r.current_slice_expired = xp;
    r.current_priority      = cpr;
    return r;
  endfunction

  // Favor a few priorities so queues get deep, but hit every value now and then.
  function automatic bit [4:0] rand_prio();
    return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
  endfunction

  function automatic req_t pick_request();
    req_t           r;
    int             roll;
    int             start;
    bit             found;
    bit [TaskW-1:0] t;
    r = mk(CMD_ELECT, 4'($urandom), rand_prio(), running_id, running_idle,
           ($urandom_range(9) == 0), 1'($urandom), rand_prio());
    roll  = $urandom_range(99);
    start = $urandom_range(15);
    found = 1'b0;
    if (roll < 40) begin
      // enqueue a task that is neither queued nor running; elect if none is free
      for (int k = 0; k < MaxTasks && !found; k++) begin
        t = TaskW'(start + k);
        if (!task_queued[t] && (running_idle || t != running_id)) begin
          found     = 1'b1;
          r.cmd     = CMD_ENQ;
          r.task_id = t;
        end
      end
    end else if (roll < 60) begin
      r.cmd = CMD_DEQ;
      if ($urandom_range(6) == 0) begin
        r.task_id = running_id;
      end else begin
        for (int k = 0; k < MaxTasks && !found; k++) begin
          t = TaskW'(start + k);
          if (task_queued[t] && task_set[t] == sb.act_sel) begin
            found          = 1'b1;
            r.task_id      = t;
            r.priority_req = task_prio[t];
          end
        end
      end
    end else if (roll >= 92) begin
      r.cmd                   = cmd_e'(2'($urandom_range(3)));
      r.task_id               = 4'($urandom);
      r.priority_req          = 5'($urandom);
      r.current_id            = 4'($urandom);
      r.current_is_idle       = 1'($urandom);
      r.current_terminated    = 1'($urandom);
      r.current_slice_expired = 1'($urandom);
      r.current_priority      = 5'($urandom);
    end
    return r;
  endfunction

  // Enter right after a rising edge; return at the edge that accepts the request.
  task automatic issue(input req_t r);
    int   gap;
    int   gap_pct;
    bit   a0;
    rsp_t p;
    gap     = 0;
    gap_pct = (idle_mode == 1) ? 66 : (idle_mode == 3) ? 31 : 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    a0 = sb.act_sel;
    p  = sb.note_request(r);
    case (r.cmd)
      CMD_ENQ: begin
        task_queued[r.task_id] = 1'b1;
        task_prio[r.task_id]   = r.priority_req;
        task_set[r.task_id]    = a0;
      end
      CMD_DEQ: begin
        if (!p.error) task_queued[r.task_id] = 1'b0;
      end
      CMD_ELECT: begin
        if (p.is_idle) begin
          running_idle = 1'b1;
        end else begin
          task_queued[p.next_id] = 1'b0;
          if (!r.current_is_idle && !r.current_terminated) begin
            task_queued[r.current_id] = 1'b1;
            task_prio[r.current_id]   = r.current_priority;
            task_set[r.current_id]    = p.reload_slice ? !sb.act_sel : sb.act_sel;
          end
          running_id   = p.next_id;
          running_idle = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    idle_mode      = 3;
    running_id     = '0;
    running_idle   = 1'b1;
    sb             = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty scheduler: idle elect, dequeue from empty queue, running-task error, unused command, idle-runner dequeue
    issue(mk(CMD_ELECT, 4'd0, 5'd0, 4'd3, 1'b0, 1'b0, 1'b0, 5'd0));
    issue(mk(CMD_DEQ, 4'd5, 5'd7, 4'd3, 1'b0, 1'b0, 1'b0, 5'd0));
    issue(mk(CMD_DEQ, 4'd3, 5'd7, 4'd3, 1'b0, 1'b0, 1'b0, 5'd0));
    issue(mk(cmd_e'(2'd3), 4'd15, 5'd31, 4'd15, 1'b1, 1'b1, 1'b1, 5'd31));
    issue(mk(CMD_DEQ, 4'd15, 5'd31, 4'd15, 1'b1, 1'b0, 1'b0, 5'd0));
    // chain every task, then append task 0 again: this writes every link once,
    // so no later request can touch a link that was never written
    for (int t = 0; t < MaxTasks; t++)
      issue(mk(CMD_ENQ, 4'(t), 5'd31, 4'd0, 1'b1, 1'b0, 1'b0, 5'd0));
    issue(mk(CMD_ENQ, 4'd0, 5'd31, 4'd0, 1'b1, 1'b0, 1'b0, 5'd0));
    // pop with expired slice, pop with requeue into the active set, pop after termination, idle runner
    issue(mk(CMD_ELECT, 4'd0, 5'd0, 4'd9, 1'b0, 1'b0, 1'b1, 5'd0));
    issue(mk(CMD_ELECT, 4'd0, 5'd0, 4'd4, 1'b0, 1'b0, 1'b0, 5'd31));
    issue(mk(CMD_ELECT, 4'd0, 5'd0, 4'd15, 1'b0, 1'b1, 1'b0, 5'd0));
    issue(mk(CMD_ELECT, 4'd0, 5'd0, 4'd0, 1'b1, 1'b0, 1'b0, 5'd0));

    for (int chunk = 0; chunk < 8; chunk++) begin
      idle_mode = chunk % 4;
      repeat (188) issue(pick_request());
    end
    req_if.valid <= 1'b0;

    while (sb.sched_rsp_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Requests: %0d enqueue, %0d dequeue, %0d elect, %0d unused command",
             sb.n_cmd[0], sb.n_cmd[1], sb.n_cmd[2], sb.n_cmd[3]);
    $display("Responses checked: %0d, idle elects %0d, slice reloads %0d, dequeue errors %0d",
             sb.n_checked, sb.n_idle, sb.n_reload, sb.n_error);
    if (sb.n_fail == 0 && sb.sched_rsp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
